// ===== rtl/core/cbmt_pkg.sv =====
`default_nettype none

package cbmt_pkg;

    // Command codes carried on the request channel
    typedef enum logic [1:0] {
        CMD_INC   = 2'd0,
        CMD_DEC   = 2'd1,
        CMD_CLR   = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    // Controller sequence
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_DRAIN
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/cbmt_ifs.sv =====
`default_nettype none

// Command request channel
interface cbmt_cmd_if #(
    parameter int IDX_W = 6
);
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic [IDX_W-1:0] counter_index;

    modport source (output valid, output cmd, output counter_index, input ready);
    modport sink   (input valid, input cmd, input counter_index, output ready);
endinterface

// Result channel
interface cbmt_res_if #(
    parameter int CNT_W = 16,
    parameter int NUM_W = 7
);
    logic                    valid;
    logic                    ready;
    logic signed [CNT_W-1:0] counter_value;
    logic signed [CNT_W-1:0] max_value;
    logic [NUM_W-1:0]        num_at_max;
    logic                    bad_index;

    modport source (output valid, output counter_value, output max_value,
                    output num_at_max, output bad_index, input ready);
    modport sink   (input valid, input counter_value, input max_value,
                    input num_at_max, input bad_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cbmt_ram.sv =====
`default_nettype none

// Single-port-write, single-port-read counter store, registered read (read-first)
module cbmt_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cbmt_ctrl.sv =====
`default_nettype none

// Sequencer: read-modify-write of one counter, incremental max tracking,
// full rescan of the active set when the sole holder drops or the active
// count was rewritten.
module cbmt_ctrl #(
    parameter int NUM_COUNTERS = 64,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic [$clog2(NUM_COUNTERS+1)-1:0]      i_active,
    input  wire logic                                   i_cfg_wr,
    cbmt_cmd_if.sink                                    i_cmd,
    cbmt_res_if.source                                  o_res
);

    localparam int IW = $clog2(NUM_COUNTERS);
    localparam int AW = $clog2(NUM_COUNTERS + 1);
    localparam int CW = COUNT_WIDTH;

    localparam logic signed [CW-1:0] CountTop    = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CountBottom = {1'b1, {(CW-1){1'b0}}};

    // Store port
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [CW-1:0] rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [CW-1:0] wr_data;

    cbmt_ram #(
        .DEPTH  (NUM_COUNTERS),
        .DATA_W (CW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    cbmt_pkg::t_state r_state, n_state;

    logic [IW-1:0]        r_ptr, n_ptr;
    logic                 r_pend, n_pend;
    logic                 r_first, n_first;
    cbmt_pkg::t_cmd       r_cmd, n_cmd;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_bad, n_bad;
    logic signed [CW-1:0] r_val, n_val;
    logic signed [CW-1:0] r_max, n_max;
    logic [AW-1:0]        r_holders, n_holders;
    logic                 r_dirty, n_dirty;
    logic signed [CW-1:0] r_best, n_best;
    logic [AW-1:0]        r_cnt, n_cnt;

    logic                 r_out_valid, n_out_valid;
    logic signed [CW-1:0] r_out_val, n_out_val;
    logic signed [CW-1:0] r_out_max, n_out_max;
    logic [AW-1:0]        r_out_num, n_out_num;
    logic                 r_out_bad, n_out_bad;

    logic                 accept;
    logic                 in_ready;
    logic                 idx_bad;
    logic                 clr_last;
    logic                 scan_last;
    logic signed [CW-1:0] old_v;
    logic signed [CW-1:0] mod_v;
    logic                 holder_drop;
    logic                 need_scan;
    logic signed [CW-1:0] inc_max;
    logic [AW-1:0]        inc_holders;
    logic signed [CW-1:0] acc_best;
    logic [AW-1:0]        acc_cnt;

    assign accept    = i_cmd.valid && in_ready;
    assign idx_bad   = AW'(i_cmd.counter_index) >= i_active;
    assign clr_last  = r_ptr == IW'(NUM_COUNTERS - 1);
    assign scan_last = AW'(r_ptr) == AW'(i_active - 1'b1);
    assign old_v     = rd_data;

    // Saturating modify of the counter read last cycle
    always_comb begin
        mod_v = old_v;
        unique case (r_cmd)
            cbmt_pkg::CMD_INC:   if (old_v < CountTop)    mod_v = old_v + 1'b1;
            cbmt_pkg::CMD_DEC:   if (old_v > CountBottom) mod_v = old_v - 1'b1;
            cbmt_pkg::CMD_CLR:   mod_v = '0;
            cbmt_pkg::CMD_QUERY: mod_v = old_v;
        endcase
    end

    // Incremental max tracking for the one counter that changed
    assign holder_drop = !r_bad && (old_v == r_max) && (r_holders == AW'(1))
                         && (mod_v < r_max);
    assign need_scan   = r_dirty || holder_drop;

    always_comb begin
        inc_max     = r_max;
        inc_holders = r_holders;
        if (!r_bad) begin
            if (mod_v > r_max) begin
                inc_max     = mod_v;
                inc_holders = AW'(1);
            end else if ((mod_v == r_max) && (old_v != r_max)) begin
                inc_holders = AW'(r_holders + 1'b1);
            end else if ((old_v == r_max) && (mod_v < r_max)) begin
                inc_holders = AW'(r_holders - 1'b1);
            end
        end
    end

    // Rescan accumulator: running max and count of entries equal to it
    always_comb begin
        acc_best = r_best;
        acc_cnt  = r_cnt;
        if (r_first || ($signed(rd_data) > r_best)) begin
            acc_best = rd_data;
            acc_cnt  = AW'(1);
        end else if ($signed(rd_data) == r_best) begin
            acc_cnt = AW'(r_cnt + 1'b1);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cbmt_pkg::S_CLEAR: if (clr_last) n_state = cbmt_pkg::S_IDLE;
            cbmt_pkg::S_IDLE:  if (accept) n_state = cbmt_pkg::S_MOD;
            cbmt_pkg::S_MOD:   n_state = need_scan ? cbmt_pkg::S_SCAN : cbmt_pkg::S_IDLE;
            cbmt_pkg::S_SCAN:  if (scan_last) n_state = cbmt_pkg::S_DRAIN;
            cbmt_pkg::S_DRAIN: n_state = cbmt_pkg::S_IDLE;
            default:           n_state = cbmt_pkg::S_IDLE;
        endcase
    end

    // Store port and handshake outputs
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_ptr;
        wr_en    = 1'b0;
        wr_addr  = r_ptr;
        wr_data  = '0;
        in_ready = 1'b0;
        unique case (r_state)
            cbmt_pkg::S_CLEAR: begin
                wr_en = 1'b1;
            end
            cbmt_pkg::S_IDLE: begin
                rd_en    = 1'b1;
                rd_addr  = i_cmd.counter_index;
                in_ready = !r_out_valid || o_res.ready;
            end
            cbmt_pkg::S_MOD: begin
                wr_en   = !r_bad;
                wr_addr = r_idx;
                wr_data = mod_v;
            end
            cbmt_pkg::S_SCAN: begin
                rd_en = 1'b1;
            end
            cbmt_pkg::S_DRAIN: begin
                rd_en = 1'b0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Datapath register updates
    always_comb begin
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_first     = r_first;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_bad       = r_bad;
        n_val       = r_val;
        n_max       = r_max;
        n_holders   = r_holders;
        n_dirty     = r_dirty || i_cfg_wr;
        n_best      = r_best;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_val   = r_out_val;
        n_out_max   = r_out_max;
        n_out_num   = r_out_num;
        n_out_bad   = r_out_bad;
        unique case (r_state)
            cbmt_pkg::S_CLEAR: begin
                n_ptr = clr_last ? '0 : IW'(r_ptr + 1'b1);
            end
            cbmt_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd = cbmt_pkg::t_cmd'(i_cmd.cmd);
                    n_idx = i_cmd.counter_index;
                    n_bad = idx_bad;
                end
            end
            cbmt_pkg::S_MOD: begin
                n_val = r_bad ? '0 : mod_v;
                if (need_scan) begin
                    n_ptr   = '0;
                    n_first = 1'b1;
                    n_pend  = 1'b0;
                end else begin
                    n_max       = inc_max;
                    n_holders   = inc_holders;
                    n_out_valid = 1'b1;
                    n_out_val   = r_bad ? '0 : mod_v;
                    n_out_max   = inc_max;
                    n_out_num   = inc_holders;
                    n_out_bad   = r_bad;
                end
            end
            cbmt_pkg::S_SCAN: begin
                n_pend = 1'b1;
                n_ptr  = IW'(r_ptr + 1'b1);
                if (r_pend) begin
                    n_best  = acc_best;
                    n_cnt   = acc_cnt;
                    n_first = 1'b0;
                end
            end
            cbmt_pkg::S_DRAIN: begin
                n_pend      = 1'b0;
                n_first     = 1'b0;
                n_max       = acc_best;
                n_holders   = acc_cnt;
                n_dirty     = i_cfg_wr;
                n_out_valid = 1'b1;
                n_out_val   = r_val;
                n_out_max   = acc_best;
                n_out_num   = acc_cnt;
                n_out_bad   = r_bad;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbmt_pkg::S_CLEAR;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
            r_max       <= '0;
            r_holders   <= AW'(NUM_COUNTERS);
            r_dirty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_first     <= n_first;
            r_max       <= n_max;
            r_holders   <= n_holders;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_bad     <= n_bad;
        r_val     <= n_val;
        r_best    <= n_best;
        r_cnt     <= n_cnt;
        r_out_val <= n_out_val;
        r_out_max <= n_out_max;
        r_out_num <= n_out_num;
        r_out_bad <= n_out_bad;
    end

    assign i_cmd.ready         = in_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.counter_value = r_out_val;
    assign o_res.max_value     = r_out_max;
    assign o_res.num_at_max    = r_out_num;
    assign o_res.bad_index     = r_out_bad;

    // The result register is always free when a modify finishes
    a_mod_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbmt_pkg::S_MOD) |-> !r_out_valid)
        else $error("result register busy at modify");

    // An accepted request always goes to modify next
    a_accept_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == cbmt_pkg::S_MOD))
        else $error("accepted request did not reach modify");

    // The scan never reads past the active set
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbmt_pkg::S_SCAN) |-> (AW'(r_ptr) < i_active))
        else $error("scan pointer beyond active count");

    // Some active counter always holds the maximum
    a_holders_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cbmt_pkg::S_CLEAR) |-> (r_holders != '0))
        else $error("holder count is zero");

endmodule

`default_nettype wire

// ===== rtl/core/counter_bank_max_tracker.sv =====
`default_nettype none

// Channel   Dir  Handshake            Payload
// i_cmd     in   valid / ready        cmd, counter_index
// o_res     out  valid / ready        counter_value, max_value, num_at_max, bad_index
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_data (active_counters)
//
// A command reads the counter, then modifies it, writes it back and
// updates the tracked maximum. When the sole holder of the maximum drops, or
// after a write of active_counters, the active set is rescanned through the
// store read port, up to the clamped active count. After reset a clearing
// pass zeroes all NUM_COUNTERS entries of the store, with no command
// accepted until it ends. A stalled result is held in the output register;
// the next command is accepted once that register is taken.
module counter_bank_max_tracker #(
    parameter int NUM_COUNTERS = 64,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [$clog2(NUM_COUNTERS+1)-1:0] i_cfg_data,
    cbmt_cmd_if.sink                               i_cmd,
    cbmt_res_if.source                             o_res
);

    localparam int AW = $clog2(NUM_COUNTERS + 1);

    logic [AW-1:0] r_active;
    logic [AW-1:0] active_n;
    logic          cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // active_counters register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= AW'(NUM_COUNTERS);
        end else if (cfg_wr) begin
            r_active <= i_cfg_data;
        end
    end

    // Clamp to 1 .. NUM_COUNTERS
    always_comb begin
        if (r_active == '0) begin
            active_n = AW'(1);
        end else if (r_active > AW'(NUM_COUNTERS)) begin
            active_n = AW'(NUM_COUNTERS);
        end else begin
            active_n = r_active;
        end
    end

    cbmt_ctrl #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_active (active_n),
        .i_cfg_wr (cfg_wr),
        .i_cmd    (i_cmd),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

// ===== bench/counter_bank_max_tracker_test.sv =====
`timescale 1ns / 1ps

module counter_bank_max_tracker_test;

    localparam int BANK_SIZE = 64;
    localparam logic signed [15:0] COUNT_TOP    = 16'sh7FFF;
    localparam logic signed [15:0] COUNT_BOTTOM = 16'sh8000;
    localparam int PHASE_ITEMS  = 78;
    localparam int SETTLE_TICKS = 80;      // longer than a full rescan

    // One result as the bank reports it
    typedef struct {
        logic signed [15:0] value;
        logic signed [15:0] peak;
        logic [6:0]         ties;
        logic               bad;
    } t_bank_report;

    typedef enum {ROW_WRITE, ROW_CHECKED, ROW_TYPED} t_row_kind;

    typedef struct {
        t_row_kind      kind;
        logic [6:0]     setting;
        cbmt_pkg::t_cmd op;
        logic [5:0]     idx;
        t_bank_report   want;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    cbmt_cmd_if #(.IDX_W(6)) cmd_if ();
    cbmt_res_if #(.CNT_W(16), .NUM_W(7)) res_if ();

    counter_bank_max_tracker #(
        .NUM_COUNTERS(BANK_SIZE),
        .COUNT_WIDTH (16)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    // Shadow copy of the bank and its register
    logic signed [15:0] bank [BANK_SIZE];
    logic [6:0]         active_reg;

    t_bank_report reports_due [$];
    t_stim_row    directed [$];
    t_bank_report no_report;
    int           mismatches = 0;
    bit           send_idle  = 1'b1;
    bit           recv_idle  = 1'b1;

    logic [6:0] phase_setting [9] = '{7'd64, 7'd2, 7'd7, 7'd1, 7'd0, 7'd127,
                                      7'd33, 7'd64, 7'd63};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Register value clamped to the usable range
    function automatic int clamped_active();
        if (active_reg < 7'd1)
            return 1;
        if (active_reg > 7'(BANK_SIZE))
            return BANK_SIZE;
        return int'(active_reg);
    endfunction

    // Apply one command to the shadow bank, then rescan the active set
    function automatic t_bank_report step_bank(input cbmt_pkg::t_cmd op,
                                               input logic [5:0] idx);
        t_bank_report       r;
        logic signed [15:0] v;
        logic signed [15:0] best;
        int                 n;
        int                 num;
        n       = clamped_active();
        r.bad   = (int'(idx) >= n);
        r.value = '0;
        if (!r.bad) begin
            v = bank[idx];
            case (op)
                cbmt_pkg::CMD_INC: if (v != COUNT_TOP) v = v + 16'sd1;
                cbmt_pkg::CMD_DEC: if (v != COUNT_BOTTOM) v = v - 16'sd1;
                cbmt_pkg::CMD_CLR: v = '0;
                default: ;
            endcase
            bank[idx] = v;
            r.value   = v;
        end
        best = bank[0];
        for (int k = 1; k < n; k++)
            if (bank[k] > best)
                best = bank[k];
        num = 0;
        for (int k = 0; k < n; k++)
            if (bank[k] == best)
                num++;
        r.peak = best;
        r.ties = 7'(num);
        return r;
    endfunction

    function automatic void add_write(input logic [6:0] setting);
        t_stim_row r;
        r.kind    = ROW_WRITE;
        r.setting = setting;
        directed  = {directed, r};
    endfunction

    // Command row; typed rows carry the expected report inline
    function automatic void add_cmd(input t_row_kind kind, input cbmt_pkg::t_cmd op,
                                    input logic [5:0] idx, input int value = 0,
                                    input int peak = 0, input int ties = 0,
                                    input bit bad = 1'b0);
        t_stim_row r;
        r.kind       = kind;
        r.setting    = '0;
        r.op         = op;
        r.idx        = idx;
        r.want.value = 16'(value);
        r.want.peak  = 16'(peak);
        r.want.ties  = 7'(ties);
        r.want.bad   = bad;
        directed     = {directed, r};
    endfunction

    // Present one request and record its expected report on acceptance
    task automatic send_cmd(input cbmt_pkg::t_cmd op, input logic [5:0] idx,
                            input bit typed, input t_bank_report want);
        t_bank_report got;
        if (send_idle && $urandom_range(99) < 19) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 19);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.cmd           <= op;
        cmd_if.counter_index <= idx;
        do @(posedge i_clk); while (!cmd_if.ready);
        got         = step_bank(op, idx);
        reports_due = {reports_due, (typed ? want : got)};
    endtask

    // Stop sending and wait for every outstanding report
    task automatic wait_bank_idle();
        cmd_if.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_active(input logic [6:0] setting);
        wait_bank_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= setting;
        do @(posedge i_clk); while (!cfg_ready);
        active_reg = setting;
        cfg_valid <= 1'b0;
    endtask

    // Result side stalls at random while recv_idle is set
    always @(posedge i_clk)
        res_if.ready <= !recv_idle || ($urandom_range(99) >= 19);

    // Compare each report against the oldest pending request
    always @(posedge i_clk) begin : check_reports
        t_bank_report due;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (reports_due.size() == 0) begin
                $display("%0t: report with no request pending", $time);
                mismatches++;
            end else begin
                due = reports_due.pop_front();
                if (res_if.counter_value !== due.value) begin
                    $display("%0t: counter_value expected %0d, got %0d",
                             $time, due.value, res_if.counter_value);
                    mismatches++;
                end
                if (res_if.max_value !== due.peak) begin
                    $display("%0t: max_value expected %0d, got %0d",
                             $time, due.peak, res_if.max_value);
                    mismatches++;
                end
                if (res_if.num_at_max !== due.ties) begin
                    $display("%0t: num_at_max expected %0d, got %0d",
                             $time, due.ties, res_if.num_at_max);
                    mismatches++;
                end
                if (res_if.bad_index !== due.bad) begin
                    $display("%0t: bad_index expected %0d, got %0d",
                             $time, due.bad, res_if.bad_index);
                    mismatches++;
                end
            end
        end
    end

    // Hang guard, ~100 ms
    initial begin
        #100_000_000;
        $display("counter_bank_max_tracker test failed");
        $finish;
    end

    initial begin
        int             n;
        int             hot;
        int             pick;
        logic [5:0]     idx;
        cbmt_pkg::t_cmd op;

        foreach (bank[k])
            bank[k] = '0;
        active_reg = 7'd64;

        i_rst_n              <= 1'b0;
        cfg_valid            <= 1'b0;
        cfg_data             <= '0;
        cmd_if.valid         <= 1'b0;
        cmd_if.cmd           <= cbmt_pkg::CMD_QUERY;
        cmd_if.counter_index <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state, index bits, sole-holder drop, bad index, clamping
        add_cmd(ROW_TYPED,   cbmt_pkg::CMD_QUERY, 6'd0,  0, 0, 64, 1'b0);
        add_cmd(ROW_TYPED,   cbmt_pkg::CMD_QUERY, 6'd63, 0, 0, 64, 1'b0);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_INC,   6'd0);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_INC,   6'd63);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_DEC,   6'd0);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_DEC,   6'd63);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_DEC,   6'd5);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_CLR,   6'd5);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_INC,   6'd42);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_INC,   6'd21);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_CLR,   6'd42);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_CLR,   6'd21);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_DEC,   6'd63);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_QUERY, 6'd63);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_INC,   6'd63);
        add_write(7'd4);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_INC,   6'd3);
        add_cmd(ROW_TYPED,   cbmt_pkg::CMD_INC,   6'd4,  0, 1, 1, 1'b1);
        add_cmd(ROW_TYPED,   cbmt_pkg::CMD_QUERY, 6'd63, 0, 1, 1, 1'b1);
        add_write(7'd0);
        add_cmd(ROW_TYPED,   cbmt_pkg::CMD_QUERY, 6'd1,  0, 0, 1, 1'b1);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_DEC,   6'd0);
        add_write(7'd127);
        add_cmd(ROW_TYPED,   cbmt_pkg::CMD_QUERY, 6'd0, -1, 1, 1, 1'b0);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_CLR,   6'd3);
        add_cmd(ROW_CHECKED, cbmt_pkg::CMD_CLR,   6'd0);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WRITE)
                write_active(directed[i].setting);
            else
                send_cmd(directed[i].op, directed[i].idx,
                         directed[i].kind == ROW_TYPED, directed[i].want);
        end

        // Random phases; most traffic on a few hot counters so the maximum moves
        phase_setting[7] = 7'($urandom_range(64, 1));
        for (int p = 0; p < 9; p++) begin
            write_active(phase_setting[p]);
            send_idle = (p != 3);
            recv_idle = (p != 3);
            n   = clamped_active();
            hot = (n < 6) ? n : 6;
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    idx = 6'($urandom_range(hot - 1, 0));
                else if (pick < 88)
                    idx = 6'($urandom_range(n - 1, 0));
                else
                    idx = 6'($urandom_range(63, 0));
                pick = $urandom_range(99);
                op = (pick < 38) ? cbmt_pkg::CMD_INC :
                     (pick < 72) ? cbmt_pkg::CMD_DEC :
                     (pick < 86) ? cbmt_pkg::CMD_CLR : cbmt_pkg::CMD_QUERY;
                send_cmd(op, idx, 1'b0, no_report);
            end
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;

        wait_bank_idle();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatches == 0)
            $display("counter_bank_max_tracker test passed");
        else
            $display("counter_bank_max_tracker test failed");
        $finish;
    end

endmodule
